>>> rtl/rgsp_pkg.sv
// Package for the radial glow sprite pixel block.
// Holds constants, register indexes and the linear-profile lookup tables.
// No dependencies.
package rgsp_pkg;

  localparam int unsigned RIM_HT     = 120;
  localparam int unsigned FULL_LEVEL = 63;
  localparam int unsigned ROUND_HALF = 1 << 15;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROFILE_MODE = 2'd0,
    REG_CORE_SIZE    = 2'd1,
    REG_HALF_RADIUS  = 2'd2
  } cfg_reg_t;

  // Core radius in half-texels for each core_size setting.
  function automatic logic [6:0] core_radius(input logic [3:0] core);
    logic [6:0] r;
    unique case (core)
      4'd0:  r = 7'd0;
      4'd1:  r = 7'd8;
      4'd2:  r = 7'd15;
      4'd3:  r = 7'd23;
      4'd4:  r = 7'd30;
      4'd5:  r = 7'd38;
      4'd6:  r = 7'd45;
      4'd7:  r = 7'd53;
      4'd8:  r = 7'd60;
      4'd9:  r = 7'd68;
      4'd10: r = 7'd75;
      4'd11: r = 7'd83;
      4'd12: r = 7'd90;
      4'd13: r = 7'd98;
      4'd14: r = 7'd105;
      default: r = 7'd113;
    endcase
    return r;
  endfunction

  // Falloff slope in 1/65536 levels per half-texel for each core_size setting.
  function automatic logic [19:0] falloff_slope(input logic [3:0] core);
    logic [19:0] k;
    unique case (core)
      4'd0:  k = 20'd34406;
      4'd1:  k = 20'd36864;
      4'd2:  k = 20'd39322;
      4'd3:  k = 20'd42565;
      4'd4:  k = 20'd45875;
      4'd5:  k = 20'd50351;
      4'd6:  k = 20'd55050;
      4'd7:  k = 20'd61623;
      4'd8:  k = 20'd68813;
      4'd9:  k = 20'd79399;
      4'd10: k = 20'd91750;
      4'd11: k = 20'd111588;
      4'd12: k = 20'd137626;
      4'd13: k = 20'd187671;
      4'd14: k = 20'd275251;
      default: k = 20'd589824;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/radial_glow_sprite_pixel.sv
// An accepted request passes the distance, root, product, sum and divide stages to the output register.
// Throughput: one texel per cycle; the whole pipeline advances together and holds
// when the output register is full and stalled.
// The square root takes two bits per stage over four stages, the bloom divide
// two quotient bits per stage over three stages.
// Reset clears the valid bits and loads the registers with mode 0, core 4, half 32.
module radial_glow_sprite_pixel (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rgsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rgsp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [6:0]                         in_col,
  input  logic [6:0]                         in_row,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [5:0]                         out_intensity
);
  import rgsp_pkg::*;

  localparam int unsigned NST = 10;

  logic       mode_r;
  logic [3:0] core_r;
  logic [7:0] half_r;

  logic            adv;
  logic [NST-1:0]  vld_r;

  // Stage 0: squared distance in half-texels.
  logic signed [7:0] dx, dy;
  logic [14:0] s1_r;

  // Stages 1..4: square root, two bits per stage.
  logic [14:0] sq_v_r    [4];
  logic [15:0] sq_root_r [4];
  logic [14:0] sq_v_nxt    [4];
  logic [15:0] sq_root_nxt [4];

  // Stage 5: products.
  logic [7:0]  rr;
  logic [6:0]  fgm;
  logic [13:0] rr2_r;
  logic [15:0] a2_r;
  logic [27:0] lprod_r;
  logic        rim5_r, core5_r;

  // Stage 6: sums and linear result.
  logic [16:0] den_r;
  logic [22:0] num_r;
  logic [5:0]  lpix_r [4];
  logic        rim_r  [4];
  logic [16:0] den_nxt;
  logic [21:0] a2x63;
  logic [28:0] lsum;
  logic [12:0] drop;
  logic [5:0]  lpix_nxt;

  // Stages 7..9: restoring divide, two quotient bits per stage.
  logic [22:0] rem_r [3];
  logic [16:0] dden_r [2];
  logic [5:0]  q_r   [2];
  logic [22:0] rem_nxt [3];
  logic [5:0]  q_nxt   [3];
  logic [5:0]  bloom;
  logic [5:0]  out_intensity_r;

  assign adv      = !vld_r[NST-1] || !out_stall;
  assign in_stall = !adv;
  assign out_valid     = vld_r[NST-1];
  assign out_intensity = out_intensity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      core_r <= 4'd4;
      half_r <= 8'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROFILE_MODE: mode_r <= cfg_wdata[0];
        REG_CORE_SIZE:    core_r <= cfg_wdata[3:0];
        REG_HALF_RADIUS:  half_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  assign dx = $signed({1'b0, in_col} << 1) - 8'sd127;
  assign dy = $signed({1'b0, in_row} << 1) - 8'sd127;

  always_comb begin
    logic [15:0] v;
    logic [15:0] rt;
    logic [15:0] bt;
    for (int j = 0; j < 4; j++) begin
      v  = (j == 0) ? {1'b0, s1_r} : {1'b0, sq_v_r[j-1]};
      rt = (j == 0) ? 16'd0 : sq_root_r[j-1];
      for (int n = 0; n < 2; n++) begin
        bt = 16'd1 << (14 - 2 * (2 * j + n));
        if (v >= rt + bt) begin
          v  = v - (rt + bt);
          rt = (rt >> 1) + bt;
        end else begin
          rt = rt >> 1;
        end
      end
      sq_v_nxt[j]    = v[14:0];
      sq_root_nxt[j] = rt;
    end
  end

  assign rr  = sq_root_r[3][7:0];
  assign fgm = core_radius(core_r);

  assign den_nxt = 17'(a2_r) + 17'(rr2_r);
  assign a2x63   = {a2_r, 6'b0} - 22'(a2_r);
  assign lsum    = 29'(lprod_r) + 29'(ROUND_HALF);
  assign drop    = lsum[28:16];
  assign lpix_nxt = core5_r ? 6'(FULL_LEVEL)
                  : (drop >= 13'(FULL_LEVEL)) ? 6'd0 : 6'(6'(FULL_LEVEL) - drop[5:0]);

  always_comb begin
    logic [22:0] rm;
    logic [5:0]  q;
    logic [16:0] d;
    logic [22:0] tr;
    for (int j = 0; j < 3; j++) begin
      rm = (j == 0) ? num_r : rem_r[j-1];
      q  = (j == 0) ? 6'd0 : q_r[j-1];
      d  = (j == 0) ? den_r : dden_r[j-1];
      for (int n = 0; n < 2; n++) begin
        tr = 23'(d) << (5 - (2 * j + n));
        if (rm >= tr) begin
          rm = rm - tr;
          q  = {q[4:0], 1'b1};
        end else begin
          q  = {q[4:0], 1'b0};
        end
      end
      rem_nxt[j] = rm;
      q_nxt[j]   = q;
    end
  end

  // A zero denominator gives all quotient bits set, which is the upper clamp.
  assign bloom = (q_nxt[2] == 6'd0) ? 6'd1 : q_nxt[2];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= 15'(dx * dx) + 15'(dy * dy);
      for (int j = 0; j < 4; j++) begin
        sq_v_r[j]    <= sq_v_nxt[j];
        sq_root_r[j] <= sq_root_nxt[j];
      end
      rr2_r   <= 14'(rr[6:0] * rr[6:0]);
      a2_r    <= half_r * half_r;
      lprod_r <= 28'((rr - {1'b0, fgm}) * falloff_slope(core_r));
      rim5_r  <= rr >= 8'(RIM_HT);
      core5_r <= rr <= {1'b0, fgm};
      den_r   <= den_nxt;
      num_r   <= 23'(a2x63) + 23'(den_nxt[16:1]);
      lpix_r[0] <= lpix_nxt;
      rim_r[0]  <= rim5_r;
      for (int j = 1; j < 4; j++) begin
        lpix_r[j] <= lpix_r[j-1];
        rim_r[j]  <= rim_r[j-1];
      end
      rem_r[0]  <= rem_nxt[0];
      rem_r[1]  <= rem_nxt[1];
      rem_r[2]  <= rem_nxt[2];
      q_r[0]    <= q_nxt[0];
      q_r[1]    <= q_nxt[1];
      dden_r[0] <= den_r;
      dden_r[1] <= dden_r[0];
      out_intensity_r <= rim_r[2] ? 6'd0 : (mode_r ? bloom : lpix_r[2]);
    end
  end

  // The unused tail of the side pipes only keeps the delay lines uniform.
  logic unused_tail;
  assign unused_tail = ^{lpix_r[3], rim_r[3], rem_r[2]};

  a_stall_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output register");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted request did not enter the pipeline");

  a_output_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[NST-2]))
    else $error("result appeared without a request behind it");

  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vld_r))
    else $error("pipeline moved while the output was stalled");

endmodule

>>> sim/tb_radial_glow_sprite_pixel.sv
// Testbench for radial_glow_sprite_pixel: directed and random texel streams
// checked against a behavioral glow predictor, with random idling on both sides.
// Depends on rtl/rgsp_pkg.sv and rtl/radial_glow_sprite_pixel.sv.
module tb_radial_glow_sprite_pixel;
  timeunit 1ns;
  timeprecision 1ps;
  import rgsp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [6:0] in_col;
  logic [6:0] in_row;
  logic out_valid;
  logic out_stall;
  logic [5:0] out_intensity;

  // Shadow copy of the block's registers.
  logic bloom_mode;
  logic [3:0] core_sel;
  logic [7:0] half_rad;

  logic [5:0] level_q[$];
  int mismatches;
  int idle_cycles;
  bit hold_req;
  bit out_take;
  logic [5:0] out_snap;

  radial_glow_sprite_pixel u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_col(in_col), .in_row(in_row),
    .out_valid(out_valid), .out_stall(out_stall), .out_intensity(out_intensity)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned root_floor(input int unsigned v);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic logic [5:0] glow_level(input logic [6:0] c, input logic [6:0] r);
    int dx;
    int dy;
    int unsigned rr;
    longint unsigned fgm;
    longint unsigned slope;
    longint unsigned drop;
    longint unsigned a2;
    longint unsigned den;
    longint unsigned v;
    dx = 2 * int'(c) - 127;
    dy = 2 * int'(r) - 127;
    rr = root_floor(dx * dx + dy * dy);
    if (rr >= RIM_HT) return 6'd0;
    if (!bloom_mode) begin
      fgm = (2 * RIM_HT * core_sel + 16) / 32;
      slope = (2 * (longint'(FULL_LEVEL) << 16) + (RIM_HT - fgm)) / (2 * (RIM_HT - fgm));
      if (rr <= fgm) return 6'(FULL_LEVEL);
      drop = ((rr - fgm) * slope + ROUND_HALF) >> 16;
      return (drop >= FULL_LEVEL) ? 6'd0 : 6'(FULL_LEVEL - drop);
    end
    a2 = half_rad * half_rad;
    den = a2 + rr * rr;
    // A zero half radius at the center has no denominator; it saturates.
    v = (den == 0) ? FULL_LEVEL : (FULL_LEVEL * a2 + den / 2) / den;
    if (v < 1) v = 1;
    if (v > FULL_LEVEL) v = FULL_LEVEL;
    return 6'(v);
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_texel(input logic [6:0] c, input logic [6:0] r, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_col <= c;
    in_row <= r;
    @(negedge clk);
    while (in_stall) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    level_q.push_back(glow_level(c, r));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == REG_PROFILE_MODE) bloom_mode = data[0];
    else if (idx == REG_CORE_SIZE) core_sel = data[3:0];
    else if (idx == REG_HALF_RADIUS) half_rad = data;
  endtask

  task automatic set_profile(input logic mode, input logic [3:0] core, input logic [7:0] h);
    wait_idle();
    write_reg(REG_PROFILE_MODE, {7'd0, mode});
    write_reg(REG_CORE_SIZE, {4'd0, core});
    write_reg(REG_HALF_RADIUS, h);
    cfg_we <= 1'b0;
  endtask

  task automatic test_corners();
    send_texel(7'd0, 7'd0, 0);
    send_texel(7'd127, 7'd127, 0);
    send_texel(7'd0, 7'd127, 0);
    send_texel(7'd63, 7'd63, 0);
    send_texel(7'd64, 7'd64, 1);
    send_texel(7'd63, 7'd0, 0);
    send_texel(7'd0, 7'd64, 0);
    send_texel(7'd90, 7'd40, 0);
  endtask

  task automatic test_core_extremes();
    set_profile(1'b0, 4'd0, 8'd32);
    send_texel(7'd63, 7'd63, 0);
    send_texel(7'd100, 7'd63, 0);
    set_profile(1'b0, 4'd15, 8'd32);
    send_texel(7'd63, 7'd63, 0);
    send_texel(7'd118, 7'd63, 0);
    send_texel(7'd122, 7'd63, 0);
  endtask

  task automatic test_bloom_extremes();
    set_profile(1'b1, 4'd4, 8'd0);
    send_texel(7'd63, 7'd63, 0);
    send_texel(7'd64, 7'd63, 0);
    send_texel(7'd100, 7'd30, 0);
    set_profile(1'b1, 4'd4, 8'd255);
    send_texel(7'd63, 7'd63, 0);
    send_texel(7'd120, 7'd63, 0);
    set_profile(1'b1, 4'd4, 8'd1);
    send_texel(7'd70, 7'd63, 0);
  endtask

  task automatic test_spare_index();
    wait_idle();
    write_reg(REG_SPARE, 8'hff);
    cfg_we <= 1'b0;
    send_texel(7'd80, 7'd70, 0);
    send_texel(7'd10, 7'd110, 0);
  endtask

  task automatic test_random_stream(input int phases, input int per_phase);
    logic [7:0] h;
    for (int p = 0; p < phases; p++) begin
      h = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1) * 255)
                                      : 8'($urandom_range(1, 255));
      set_profile(1'($urandom), 4'($urandom_range(0, 15)), h);
      for (int i = 0; i < per_phase; i++) begin
        send_texel(7'($urandom), 7'($urandom), (i % 40 < 10) ? 0 : pick_gap());
      end
    end
  endtask

  task automatic test_backpressure();
    set_profile(1'b0, 4'd7, 8'd32);
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) send_texel(7'($urandom), 7'($urandom), 0);
  endtask

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin
    int left;
    out_stall = 1'b0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (left > 0) begin
        left--;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  always @(negedge clk) begin
    out_take <= out_valid && !out_stall && rst_n;
    out_snap <= out_intensity;
  end

  always @(posedge clk) begin
    if (out_take) begin
      idle_cycles = 0;
      if (level_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result intensity=%0d", out_snap);
      end else begin
        logic [5:0] want;
        want = level_q.pop_front();
        if (want !== out_snap) begin
          mismatches++;
          if (mismatches <= 10)
            $display("intensity mismatch: expected %0d got %0d", want, out_snap);
        end
      end
    end
  end

  // Watchdog on cycles in which no request and no result moves.
  always @(posedge clk) begin
    if (in_valid && !in_stall) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_col = '0;
    in_row = '0;
    bloom_mode = 1'b0;
    core_sel = 4'd4;
    half_rad = 8'd32;
    mismatches = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    test_core_extremes();
    test_bloom_extremes();
    test_spare_index();
    test_backpressure();
    test_random_stream(13, 145);
    wait_idle();
    if (mismatches == 0 && level_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rgsp_pkg.sv
rtl/radial_glow_sprite_pixel.sv
sim/tb_radial_glow_sprite_pixel.sv
